// ===== rtl/fbpa_pkg.sv =====
package fbpa_pkg;

  // operation codes carried in s_tuser
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // result status carried in m_tuser
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EXHAUSTED = 2'd1,
    STS_MISMATCH  = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_POOL_BYTES  = 2'd1;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd2;
  localparam logic [1:0] REG_BLOCK_ALIGN = 2'd3;

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    U_DISPATCH,
    U_ACHK,
    U_AMUL,
    U_APOP,
    U_RSTART,
    U_DIV,
    U_RPUSH,
    U_BSTART,
    U_BALIGN,
    U_BCOUNT,
    U_BSET,
    U_FILL,
    U_FINISH,
    U_NOP
  } act_t;

  // sequencing mode
  typedef enum logic [1:0] {
    SEQ_NEXT,  // always step + 1
    SEQ_JUMP,  // always target
    SEQ_BR,    // cond ? target : step + 1
    SEQ_WAIT   // cond ? target : stay
  } seq_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ACCEPT,
    C_ALLOC_SKIP,
    C_NO_POOL,
    C_DIV_LAST,
    C_QZERO,
    C_FILL_LAST,
    C_OUT_FREE
  } cond_t;

  localparam int PCW = 4;
  typedef logic [PCW-1:0] pc_t;

  // program addresses
  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_ACHK   = 4'd1;
  localparam pc_t PC_AMUL   = 4'd2;
  localparam pc_t PC_APOP   = 4'd3;
  localparam pc_t PC_RSTART = 4'd4;
  localparam pc_t PC_RDIV   = 4'd5;
  localparam pc_t PC_RPUSH  = 4'd6;
  localparam pc_t PC_BSTART = 4'd7;
  localparam pc_t PC_BDIV1  = 4'd8;
  localparam pc_t PC_BALIGN = 4'd9;
  localparam pc_t PC_BCOUNT = 4'd10;
  localparam pc_t PC_BDIV2  = 4'd11;
  localparam pc_t PC_BSET   = 4'd12;
  localparam pc_t PC_FILL   = 4'd13;
  localparam pc_t PC_FIN    = 4'd14;

  typedef struct packed {
    act_t  act;
    seq_t  seq;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  // control store
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    c = '{act: U_NOP, seq: SEQ_JUMP, cond: C_NONE, target: PC_IDLE};
    case (pc)
      PC_IDLE:   c = '{act: U_DISPATCH, seq: SEQ_WAIT, cond: C_ACCEPT,     target: PC_IDLE};
      PC_ACHK:   c = '{act: U_ACHK,     seq: SEQ_BR,   cond: C_ALLOC_SKIP, target: PC_FIN};
      PC_AMUL:   c = '{act: U_AMUL,     seq: SEQ_NEXT, cond: C_NONE,       target: PC_IDLE};
      PC_APOP:   c = '{act: U_APOP,     seq: SEQ_JUMP, cond: C_NONE,       target: PC_FIN};
      PC_RSTART: c = '{act: U_RSTART,   seq: SEQ_BR,   cond: C_NO_POOL,    target: PC_FIN};
      PC_RDIV:   c = '{act: U_DIV,      seq: SEQ_WAIT, cond: C_DIV_LAST,   target: PC_RPUSH};
      PC_RPUSH:  c = '{act: U_RPUSH,    seq: SEQ_JUMP, cond: C_NONE,       target: PC_FIN};
      PC_BSTART: c = '{act: U_BSTART,   seq: SEQ_NEXT, cond: C_NONE,       target: PC_IDLE};
      PC_BDIV1:  c = '{act: U_DIV,      seq: SEQ_WAIT, cond: C_DIV_LAST,   target: PC_BALIGN};
      PC_BALIGN: c = '{act: U_BALIGN,   seq: SEQ_NEXT, cond: C_NONE,       target: PC_IDLE};
      PC_BCOUNT: c = '{act: U_BCOUNT,   seq: SEQ_NEXT, cond: C_NONE,       target: PC_IDLE};
      PC_BDIV2:  c = '{act: U_DIV,      seq: SEQ_WAIT, cond: C_DIV_LAST,   target: PC_BSET};
      PC_BSET:   c = '{act: U_BSET,     seq: SEQ_BR,   cond: C_QZERO,      target: PC_FIN};
      PC_FILL:   c = '{act: U_FILL,     seq: SEQ_WAIT, cond: C_FILL_LAST,  target: PC_FIN};
      PC_FIN:    c = '{act: U_FINISH,   seq: SEQ_WAIT, cond: C_OUT_FREE,   target: PC_IDLE};
      default:   c = '{act: U_NOP,      seq: SEQ_JUMP, cond: C_NONE,       target: PC_IDLE};
    endcase
    return c;
  endfunction

  // first step of each operation
  function automatic pc_t op_entry(input op_t op);
    pc_t pc;
    pc = PC_FIN;
    case (op)
      OP_ALLOC:   pc = PC_ACHK;
      OP_RELEASE: pc = PC_RSTART;
      OP_REBUILD: pc = PC_BSTART;
      OP_NONE:    pc = PC_FIN;
      default:    pc = PC_FIN;
    endcase
    return pc;
  endfunction

endpackage

// ===== rtl/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator with a last-in-first-out free list.
//
// Commands arrive on the s_* stream: s_tuser holds the operation (allocate,
// release, rebuild, none) and s_tdata its operands. Each command gives one
// result word on the m_* stream: status in m_tuser, and the block address,
// bytes in use and live block count in m_tdata. Layout registers are written
// on the cfg_* channel, by the user only while the block is idle (the block
// does not enforce it); they shape the pool at the next rebuild, and allocate
// checks requests against them directly.
// A microcoded sequencer runs one command at a time. Per command, from accept
// to result loaded, the steps are:
//   allocate checks, multiplies and pops (a rejected request only checks),
//   no operation goes straight to the finish step, release runs the
//   bit-serial divider over DW bits before its push (not while no pool is built),
//   rebuild two divides plus one link write per block.
// DW is the larger of ADDR_WIDTH and 32.
// The result sits in an output register; a new command is accepted while it
// waits, but the next result holds in the finish step until m_tready frees it.
// After reset the free list is empty and every matching allocate reports
// exhaustion until a rebuild; the link memory needs no clearing pass.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // release_address, request_size, request_alignment
  input  logic [1:0]  s_tuser,   // op
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // block_address, bytes_in_use, live_blocks
  output logic [1:0]  m_tuser,   // status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fbpa_pkg::*;

  localparam int AW  = ADDR_WIDTH;
  localparam int IW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int DW  = (AW > 32) ? AW : 32;
  localparam int DCW = $clog2(DW);
  localparam int PW  = IW + 16;
  localparam int SW  = (AW > PW) ? AW : PW;

  // configuration registers
  logic [31:0] pool_base_address;
  logic [20:0] pool_bytes;
  logic [15:0] block_bytes;
  logic [7:0]  block_alignment;

  // allocator state
  logic [CW-1:0] link_mem [MAX_BLOCKS];
  logic [CW-1:0] link_rd;
  logic          head_valid;
  logic [IW-1:0] list_head;
  logic [AW-1:0] aligned_base;
  logic [20:0]   used_bytes;
  logic [10:0]   live_count;
  logic [CW-1:0] latched_count;
  logic [15:0]   latched_block;

  // sequencer
  pc_t  upc, upc_next;
  ctl_t ctl;
  logic cond_hit;

  // working registers
  logic [31:0]   in_rel;
  logic [15:0]   in_size;
  logic [7:0]    in_align;
  status_t       status_r;
  logic [AW-1:0] addr_r;
  logic [PW-1:0] prod;
  logic [7:0]    adj_r;
  logic [IW-1:0] fill_idx;
  logic [DW-1:0] div_quo;
  logic [15:0]   div_rem;
  logic [15:0]   div_den;
  logic [DCW-1:0] div_cnt;

  // datapath terms
  logic          mismatch;
  logic          out_free;
  logic [7:0]    align_eff;
  logic [7:0]    adj_c;
  logic [32:0]   base_sum;
  logic [AW-1:0] off_c;
  logic [SW-1:0] addr_sum;
  logic          cnt_ok;
  logic [20:0]   pool_rem_c;
  logic [CW-1:0] count_c;
  logic          rel_hit;
  logic          fill_last;
  logic [16:0]   div_trial;
  logic          div_ge;
  logic [21:0]   used_add;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [CW-1:0] link_wdata;

  assign cfg_ready = 1'b1;
  assign ctl       = ucode(upc);
  assign s_tready  = (ctl.act == U_DISPATCH);
  assign out_free  = !m_tvalid || m_tready;

  // combinational datapath terms
  always_comb begin
    mismatch   = (in_size == '0) || (in_size != block_bytes) || (in_align != block_alignment);
    align_eff  = (block_alignment == '0) ? 8'd1 : block_alignment;
    adj_c      = (div_rem == '0) ? 8'd0 : (align_eff - div_rem[7:0]);
    base_sum   = {1'b0, pool_base_address} + 33'(adj_r);
    off_c      = AW'(in_rel) - aligned_base;
    addr_sum   = SW'(aligned_base) + SW'(prod);
    cnt_ok     = (block_bytes != '0) && (pool_bytes > 21'(adj_r));
    pool_rem_c = pool_bytes - 21'(adj_r);
    count_c    = (div_quo > DW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : div_quo[CW-1:0];
    rel_hit    = div_quo < DW'(latched_count);
    fill_last  = (CW'(fill_idx) + CW'(1)) == latched_count;
    div_trial  = {div_rem, div_quo[DW-1]};
    div_ge     = div_trial >= {1'b0, div_den};
    used_add   = {1'b0, used_bytes} + 22'(latched_block);
  end

  // branch condition
  always_comb begin
    case (ctl.cond)
      C_NONE:       cond_hit = 1'b0;
      C_ACCEPT:     cond_hit = s_tvalid;
      C_ALLOC_SKIP: cond_hit = mismatch || !head_valid;
      C_NO_POOL:    cond_hit = (latched_count == '0);
      C_DIV_LAST:   cond_hit = (div_cnt == DCW'(DW - 1));
      C_QZERO:      cond_hit = (div_quo == '0);
      C_FILL_LAST:  cond_hit = fill_last;
      C_OUT_FREE:   cond_hit = out_free;
      default:      cond_hit = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_t tgt;
    tgt = (ctl.act == U_DISPATCH) ? op_entry(op_t'(s_tuser)) : ctl.target;
    case (ctl.seq)
      SEQ_NEXT: upc_next = upc + pc_t'(1);
      SEQ_JUMP: upc_next = tgt;
      SEQ_BR:   upc_next = cond_hit ? tgt : upc + pc_t'(1);
      SEQ_WAIT: upc_next = cond_hit ? tgt : upc;
      default:  upc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= PC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // link memory write port
  always_comb begin
    link_we    = 1'b0;
    link_waddr = fill_idx;
    link_wdata = fill_last ? CW'(MAX_BLOCKS) : (CW'(fill_idx) + CW'(1));
    case (ctl.act)
      U_FILL: begin
        link_we = 1'b1;
      end
      U_RPUSH: begin
        link_we    = rel_hit;
        link_waddr = div_quo[IW-1:0];
        link_wdata = head_valid ? CW'(list_head) : CW'(MAX_BLOCKS);
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd <= link_mem[list_head];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base_address <= '0;
      pool_bytes        <= 21'd16384;
      block_bytes       <= 16'd16;
      block_alignment   <= 8'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POOL_BASE:   pool_base_address <= cfg_data;
        REG_POOL_BYTES:  pool_bytes        <= cfg_data[20:0];
        REG_BLOCK_BYTES: block_bytes       <= cfg_data[15:0];
        REG_BLOCK_ALIGN: block_alignment   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // free list and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid    <= 1'b0;
      list_head     <= '0;
      aligned_base  <= '0;
      used_bytes    <= '0;
      live_count    <= '0;
      latched_count <= '0;
      latched_block <= '0;
    end else begin
      case (ctl.act)
        U_APOP: begin
          head_valid <= (link_rd != CW'(MAX_BLOCKS));
          list_head  <= link_rd[IW-1:0];
          used_bytes <= used_add[21] ? '1 : used_add[20:0];
          live_count <= (live_count == '1) ? live_count : live_count + 11'd1;
        end
        U_RPUSH: begin
          if (rel_hit) begin
            list_head  <= div_quo[IW-1:0];
            head_valid <= 1'b1;
            used_bytes <= (used_bytes > 21'(latched_block)) ?
                          (used_bytes - 21'(latched_block)) : '0;
            live_count <= (live_count == '0) ? '0 : live_count - 11'd1;
          end
        end
        U_BCOUNT: begin
          aligned_base  <= AW'(base_sum);
          latched_block <= block_bytes;
        end
        U_BSET: begin
          latched_count <= count_c;
          head_valid    <= (count_c != '0);
          list_head     <= '0;
          used_bytes    <= '0;
          live_count    <= '0;
        end
        default: ;
      endcase
    end
  end

  // operands, divider and result staging
  always_ff @(posedge clk) begin
    case (ctl.act)
      U_DISPATCH: begin
        if (s_tvalid) begin
          in_rel   <= s_tdata[31:0];
          in_size  <= s_tdata[47:32];
          in_align <= s_tdata[55:48];
          status_r <= STS_OK;
          addr_r   <= '0;
        end
      end
      U_ACHK: begin
        status_r <= mismatch ? STS_MISMATCH : (!head_valid ? STS_EXHAUSTED : STS_OK);
      end
      U_AMUL: begin
        prod <= PW'(list_head) * PW'(latched_block);
      end
      U_APOP: begin
        addr_r <= addr_sum[AW-1:0];
      end
      U_RSTART: begin
        div_quo <= DW'(off_c);
        div_rem <= '0;
        div_den <= latched_block;
        div_cnt <= '0;
      end
      U_BSTART: begin
        div_quo <= DW'(pool_base_address);
        div_rem <= '0;
        div_den <= 16'(align_eff);
        div_cnt <= '0;
      end
      U_DIV: begin
        // restoring division, one quotient bit per step
        div_rem <= div_ge ? 16'(div_trial - {1'b0, div_den}) : div_trial[15:0];
        div_quo <= {div_quo[DW-2:0], div_ge};
        div_cnt <= div_cnt + DCW'(1);
      end
      U_BALIGN: begin
        adj_r <= adj_c;
      end
      U_BCOUNT: begin
        div_quo <= cnt_ok ? DW'(pool_rem_c) : '0;
        div_rem <= '0;
        div_den <= cnt_ok ? block_bytes : 16'd1;
        div_cnt <= '0;
      end
      U_BSET: begin
        fill_idx <= '0;
      end
      U_FILL: begin
        fill_idx <= fill_idx + IW'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.act == U_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act == U_FINISH && out_free) begin
      m_tdata <= {live_count, used_bytes, 32'(addr_r)};
      m_tuser <= status_r;
    end
  end

  // checks
  a_head_needs_pool: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> latched_count != '0)
    else $error("free list head valid with an empty pool");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> upc != PC_IDLE)
    else $error("sequencer stayed idle after a command was taken");

  a_div_starts_clean: assert property (@(posedge clk) disable iff (rst)
    (ctl.act == U_DIV && $past(ctl.act) != U_DIV) |-> div_cnt == '0)
    else $error("divider entered without a start");

  a_fill_in_pool: assert property (@(posedge clk) disable iff (rst)
    ctl.act == U_FILL |-> CW'(fill_idx) < latched_count)
    else $error("link fill past the block count");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctl.act == U_FINISH))
    else $error("result word loaded outside the finish step");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

import fbpa_pkg::*;

localparam int unsigned POOL_MAX_BLOCKS = 1024;
localparam int unsigned USED_SAT = 32'h1F_FFFF;

// one result word as it leaves the allocator
typedef struct {
  status_t   status;
  bit [31:0] block_addr;
  bit [20:0] used_bytes;
  bit [10:0] live_blocks;
} pool_result_t;

// free-list predictor plus the queue of results still owed by the allocator
class pool_scoreboard;
  // layout registers as last written
  bit [31:0] reg_base;
  bit [20:0] reg_pool;
  bit [15:0] reg_block;
  bit [7:0]  reg_align;
  // layout latched at rebuild, free list and counters
  bit [10:0] next_free [POOL_MAX_BLOCKS];
  bit        head_ok;
  bit [9:0]  head;
  bit [31:0] pool_start;
  bit [10:0] pool_blocks;
  bit [15:0] pool_block_bytes;
  bit [20:0] used;
  bit [10:0] live;
  pool_result_t pending_results[$];
  int unsigned errors;

  function new();
    reg_base = '0;
    reg_pool = 21'd16384;
    reg_block = 16'd16;
    reg_align = 8'd8;
    head_ok = 1'b0;
    head = '0;
    pool_start = '0;
    pool_blocks = '0;
    pool_block_bytes = '0;
    used = '0;
    live = '0;
    errors = 0;
    foreach (next_free[i]) next_free[i] = '0;
  endfunction

  function void write_reg(bit [1:0] idx, bit [31:0] data);
    case (idx)
      REG_POOL_BASE:   reg_base = data;
      REG_POOL_BYTES:  reg_pool = data[20:0];
      REG_BLOCK_BYTES: reg_block = data[15:0];
      REG_BLOCK_ALIGN: reg_align = data[7:0];
      default: ;
    endcase
  endfunction

  // predict the result of an accepted command and queue it
  function pool_result_t note_command(op_t op, bit [31:0] rel, bit [15:0] size,
                                      bit [7:0] align);
    pool_result_t r;
    bit [10:0] nxt;
    bit [31:0] offset;
    bit [31:0] idx;
    int unsigned sum;
    int unsigned al;
    int unsigned slack;
    int unsigned count;
    r.status = STS_OK;
    r.block_addr = '0;
    case (op)
      OP_ALLOC: begin
        if (size == 0 || size != reg_block || align != reg_align) begin
          r.status = STS_MISMATCH;
        end else if (!head_ok) begin
          r.status = STS_EXHAUSTED;
        end else begin
          r.block_addr = pool_start + head * pool_block_bytes;
          nxt = next_free[head];
          head_ok = nxt != 11'(POOL_MAX_BLOCKS);
          head = nxt[9:0];
          sum = used + pool_block_bytes;
          used = (sum > USED_SAT) ? 21'(USED_SAT) : 21'(sum);
          if (live != 11'h7FF) live = live + 1'b1;
        end
      end
      OP_RELEASE: begin
        // addresses past the latched pool are dropped silently
        if (pool_blocks != 0 && pool_block_bytes != 0) begin
          offset = rel - pool_start;
          idx = offset / pool_block_bytes;
          if (idx < pool_blocks) begin
            next_free[idx[9:0]] = head_ok ? {1'b0, head} : 11'(POOL_MAX_BLOCKS);
            head = idx[9:0];
            head_ok = 1'b1;
            used = (used > pool_block_bytes) ? used - pool_block_bytes : '0;
            if (live != 0) live = live - 1'b1;
          end
        end
      end
      OP_REBUILD: begin
        // align base up, carve blocks, chain them in ascending order
        al = (reg_align == 0) ? 1 : reg_align;
        slack = (al - (reg_base % al)) % al;
        pool_start = reg_base + slack;
        pool_block_bytes = reg_block;
        count = 0;
        if (reg_block != 0 && reg_pool > slack) count = (reg_pool - slack) / reg_block;
        if (count > POOL_MAX_BLOCKS) count = POOL_MAX_BLOCKS;
        pool_blocks = 11'(count);
        for (int unsigned i = 0; i < count; i++)
          next_free[i[9:0]] = (i + 1 == count) ? 11'(POOL_MAX_BLOCKS) : 11'(i + 1);
        head_ok = count > 0;
        head = '0;
        used = '0;
        live = '0;
      end
      default: ;
    endcase
    r.used_bytes = used;
    r.live_blocks = live;
    pending_results.push_back(r);
    return r;
  endfunction

  function void check_result(bit [1:0] status, bit [31:0] addr, bit [20:0] used_now,
                             bit [10:0] live_now);
    pool_result_t e;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected word: status %0d addr %h used %0d live %0d",
               $time, status, addr, used_now, live_now);
      return;
    end
    e = pending_results.pop_front();
    if (status != e.status) begin
      errors++;
      $display("%0t: status expected %0d, got %0d", $time, e.status, status);
    end
    if (addr != e.block_addr) begin
      errors++;
      $display("%0t: block_address expected %h, got %h", $time, e.block_addr, addr);
    end
    if (used_now != e.used_bytes) begin
      errors++;
      $display("%0t: bytes_in_use expected %0d, got %0d", $time, e.used_bytes, used_now);
    end
    if (live_now != e.live_blocks) begin
      errors++;
      $display("%0t: live_blocks expected %0d, got %0d", $time, e.live_blocks, live_now);
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 1400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;    // release_address, request_size, request_alignment
  logic [1:0]  s_tuser = '0;    // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // block_address, bytes_in_use, live_blocks
  logic [1:0]  m_tuser;         // status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pool_scoreboard sb = new();
  bit [31:0]      held_blocks[$];   // addresses handed out and not yet returned
  int unsigned    burst_left = 0;
  int unsigned    sent = 0;
  int unsigned    cycle_count = 0;

  fixed_block_pool_allocator u_dut (.*);

  always #4 clk = ~clk;

  // command word, sent in bursts with random gaps
  task automatic send_command(op_t op, bit [31:0] rel, bit [15:0] size, bit [7:0] align);
    int unsigned gap;
    pool_result_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 48);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {align, size, rel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = sb.note_command(op, rel, size, align);
    if (op == OP_ALLOC && r.status == STS_OK) held_blocks.push_back(r.block_addr);
    if (op == OP_REBUILD) held_blocks.delete();
    sent++;
  endtask

  // stop sending and wait until every result word is back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write; bits above the register width get noise now and then
  task automatic write_reg(bit [1:0] idx, bit [31:0] data);
    bit [31:0] keep;
    case (idx)
      REG_POOL_BYTES:  keep = 32'h1F_FFFF;
      REG_BLOCK_BYTES: keep = 32'hFFFF;
      REG_BLOCK_ALIGN: keep = 32'hFF;
      default:         keep = '1;
    endcase
    if ($urandom_range(0, 7) == 0) data = (data & keep) | ($urandom & ~keep);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic alloc_ok();
    send_command(OP_ALLOC, $urandom, sb.reg_block, sb.reg_align);
  endtask

  // new layout: mostly small pools, now and then the extremes
  task automatic pick_layout();
    bit [31:0] base;
    bit [31:0] blk;
    bit [31:0] pool;
    bit [31:0] align;
    case ($urandom_range(0, 5))
      0:       base = 32'h0;
      1:       base = 32'hFFFF_FFFF;
      2:       base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
      default: base = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       align = 0;
      1:       align = $urandom_range(1, 255);
      default: align = 32'd1 << $urandom_range(0, 7);
    endcase
    case ($urandom_range(0, 19))
      0: begin
        blk = 4;
        pool = $urandom_range(0, 1) ? 32'h10_0000 : 32'h1F_FFFF;
      end
      1: begin
        blk = 65535;
        pool = $urandom_range(0, 32'h1F_FFFF);
      end
      2: begin
        blk = $urandom_range(4, 65535);
        pool = $urandom_range(0, 64);
      end
      3: begin
        blk = 0;
        pool = $urandom_range(0, 4096);
      end
      4: begin
        blk = $urandom_range(4, 64);
        pool = 0;
      end
      default: begin
        blk = $urandom_range(4, 300);
        pool = blk * $urandom_range(1, 40) + $urandom_range(0, 200);
      end
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(REG_POOL_BASE, base);
    if ($urandom_range(0, 3) != 0) write_reg(REG_POOL_BYTES, pool);
    if ($urandom_range(0, 3) != 0) write_reg(REG_BLOCK_BYTES, blk);
    if ($urandom_range(0, 3) != 0) write_reg(REG_BLOCK_ALIGN, align);
  endtask

  task automatic random_command();
    int unsigned pick;
    int unsigned k;
    bit [31:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      alloc_ok();
    end else if (pick < 75 && held_blocks.size() != 0) begin
      // return a held block at a random byte inside it; sometimes keep it
      // so that it is returned twice
      k = $urandom_range(0, held_blocks.size() - 1);
      addr = held_blocks[k] + 32'($urandom_range(0, sb.pool_block_bytes - 1));
      if ($urandom_range(0, 15) != 0) held_blocks.delete(k);
      send_command(OP_RELEASE, addr, 16'($urandom), 8'($urandom));
    end else if (pick < 85) begin
      send_command(OP_RELEASE, $urandom, 16'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      send_command(OP_ALLOC, $urandom, 16'($urandom), 8'($urandom));
    end else if (pick < 94) begin
      // near miss: one of size and alignment is right
      if ($urandom_range(0, 1) != 0)
        send_command(OP_ALLOC, $urandom, sb.reg_block, 8'($urandom));
      else
        send_command(OP_ALLOC, $urandom, 16'($urandom), sb.reg_align);
    end else if (pick < 98) begin
      send_command(OP_NONE, $urandom, 16'($urandom), 8'($urandom));
    end else begin
      send_command(OP_REBUILD, $urandom, 16'($urandom), 8'($urandom));
    end
  endtask

  // result side stalls on a repeating 16-bit mask that is reshuffled periodically
  initial begin
    bit [15:0] stall_mask;
    int unsigned tick;
    stall_mask = '1;
    tick = 0;
    forever begin
      @(negedge clk);
      if (tick % 256 == 0) stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      m_tready <= stall_mask[tick % 16];
      tick++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[31:0], m_tdata[52:32], m_tdata[63:53]);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned stop_at;
    int unsigned n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset layout, nothing rebuilt yet: empty list, releases ignored
    send_command(OP_ALLOC, 32'h0, 16'd16, 8'd8);
    send_command(OP_RELEASE, 32'h0, 16'd16, 8'd8);
    send_command(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    // malformed requests
    send_command(OP_ALLOC, 32'h0, 16'd0, 8'd8);
    send_command(OP_ALLOC, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_command(OP_ALLOC, 32'h0, 16'd16, 8'd0);
    // full pool of 1024 blocks
    send_command(OP_REBUILD, 32'h0, 16'h0, 8'h0);
    repeat (3) alloc_ok();
    // far outside, just past the pool, then block 1 returned twice
    send_command(OP_RELEASE, 32'hFFFF_FFFF, 16'h0, 8'h0);
    send_command(OP_RELEASE, 32'd16384, 16'h0, 8'h0);
    send_command(OP_RELEASE, 32'd31, 16'h0, 8'h0);
    send_command(OP_RELEASE, 32'd20, 16'h0, 8'h0);
    repeat (3) alloc_ok();
    send_command(OP_NONE, 32'h0, 16'h0, 8'h0);

    // two-block pool runs dry
    drain();
    write_reg(REG_POOL_BYTES, 32'd40);
    send_command(OP_REBUILD, 32'h0, 16'h0, 8'h0);
    repeat (3) alloc_ok();

    // zero block size leaves the pool empty
    drain();
    write_reg(REG_BLOCK_BYTES, 32'd0);
    send_command(OP_REBUILD, 32'h0, 16'h0, 8'h0);
    send_command(OP_ALLOC, 32'h0, 16'd0, 8'd8);
    send_command(OP_RELEASE, 32'd8, 16'h0, 8'h0);

    // block 5 returned twice on an idle pool links to itself, so allocation
    // never runs dry and the byte counter reaches its ceiling
    drain();
    write_reg(REG_POOL_BASE, 32'h8000_0000);
    write_reg(REG_POOL_BYTES, 32'h1F_FFFF);
    write_reg(REG_BLOCK_BYTES, 32'd65535);
    write_reg(REG_BLOCK_ALIGN, 32'd1);
    send_command(OP_REBUILD, 32'h0, 16'h0, 8'h0);
    send_command(OP_RELEASE, 32'h8004_FFFB + 32'd7, 16'h0, 8'h0);
    send_command(OP_RELEASE, 32'h8004_FFFB, 16'h0, 8'h0);
    repeat (40) alloc_ok();
    repeat (3) send_command(OP_RELEASE, 32'h8004_FFFB, 16'h0, 8'h0);
    held_blocks.delete();

    // random phases, each with its own layout
    stop_at = sent + RANDOM_ITEMS;
    while (sent < stop_at) begin
      drain();
      pick_layout();
      if ($urandom_range(0, 7) != 0)
        send_command(OP_REBUILD, $urandom, 16'($urandom), 8'($urandom));
      n = $urandom_range(20, 90);
      repeat (n) random_command();
    end

    drain();
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
